// ===== rtl/tfs_pkg.sv =====
`timescale 1ns / 1ps

package tfs_pkg;

  // Defaults for the top-level parameters.
  localparam int MaxFramesDef   = 16;
  localparam int FrameIdBitsDef = 8;

  // Field and datapath widths.
  localparam int TimerW  = 24;
  localparam int CountW  = 5;
  localparam int PosW    = 4;
  localparam int DtW     = 16;
  localparam int KindW   = 2;
  localparam int FidW    = 8;
  localparam int BlendW  = 9;
  localparam int EventW  = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 32;
  localparam int DivW    = TimerW + 1;
  localparam int StepW   = 5;
  localparam int ProdW   = TimerW + CountW;
  localparam int BaseW   = TimerW + PosW;
  localparam int OutW    = 40;

  localparam logic [TimerW-1:0] DurationRst = TimerW'(256000);
  localparam logic [CountW-1:0] CountRst    = CountW'(1);
  localparam logic [BlendW-1:0] BlendOne    = BlendW'(256);

  // Iteration counts of the shared divider for each of its uses.
  localparam logic [StepW-1:0] StepsMod   = StepW'(DivW);
  localparam logic [StepW-1:0] StepsPos   = StepW'(PosW);
  localparam logic [StepW-1:0] StepsBlend = StepW'(8);

  // Request kinds.
  localparam logic [KindW-1:0] KindTick  = KindW'(0);
  localparam logic [KindW-1:0] KindStart = KindW'(1);
  localparam logic [KindW-1:0] KindStop  = KindW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    REG_DURATION = 3'd0,
    REG_COUNT    = 3'd1,
    REG_LOOPING  = 3'd2,
    REG_WRAP     = 3'd3,
    REG_MAP0     = 3'd4,
    REG_MAP1     = 3'd5,
    REG_MAP2     = 3'd6,
    REG_MAP3     = 3'd7
  } cfg_reg_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_LOOP  = 2'd2,
    EV_END   = 2'd3
  } event_e;

  typedef struct packed {
    logic [TimerW-1:0] duration;
    logic [CountW-1:0] frame_count;
    logic              looping;
    logic              wrap_frames;
  } cfg_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_TICK_SUM,
    DP_TICK_END,
    DP_MOD_SUM,
    DP_MOD_TIMER,
    DP_LOOP_SET,
    DP_START_SET,
    DP_STOP,
    DP_POS_MUL,
    DP_POS_DIV,
    DP_POS_FORCE,
    DP_POS_CHANGE,
    DP_BLEND_MUL,
    DP_BLEND_SUB,
    DP_BLEND_CHK,
    DP_BLEND_SET,
    DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             running;
    logic             sum_ge;
    logic             looping;
    logic             div_done;
    logic             blend_direct;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD_WAIT,
    ST_START_WAIT,
    ST_POS_MUL,
    ST_POS_DIV,
    ST_POS_WAIT,
    ST_BLEND_MUL,
    ST_BLEND_SUB,
    ST_BLEND_CHK,
    ST_BLEND_WAIT,
    ST_OUT
  } ctrl_state_e;

endpackage

// ===== rtl/tfs_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The partial remainder is
// preloaded and the numerator bits are shifted in from the top.
module tfs_div import tfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TimerW-1:0] rem_init_i,
  input  logic [DivW-1:0]   num_i,
  input  logic [StepW-1:0]  steps_i,
  input  logic [TimerW-1:0] divisor_i,
  output logic              done_o,
  output logic [TimerW-1:0] rem_o,
  output logic [DivW-1:0]   quo_o
);

  logic [TimerW-1:0] rem_q;
  logic [DivW-1:0]   num_q;
  logic [DivW-1:0]   quo_q;
  logic [TimerW-1:0] dvs_q;
  logic [StepW-1:0]  cnt_q;
  logic              done_q;
  logic [DivW-1:0]   trial;
  logic [DivW-1:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, num_q[DivW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= steps_i;
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - StepW'(1);
      done_q <= (cnt_q == StepW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      num_q <= num_i;
      quo_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[TimerW-1:0] : trial[TimerW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
      num_q <= {num_q[DivW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/tfs_dp.sv =====
`timescale 1ns / 1ps

// Sequencer datapath: timer and position state, the frame table, the two
// small multipliers, the shared divider and the result register.
module tfs_dp import tfs_pkg::*; #(
  parameter int MAX_FRAMES    = MaxFramesDef,
  parameter int FRAME_ID_BITS = FrameIdBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               map_we_i,
  input  logic [CfgIdxW-1:0] map_idx_i,
  input  logic [CfgW-1:0]    map_data_i,
  input  logic [KindW-1:0]   kind_i,
  input  logic [DtW-1:0]     dt_i,
  input  dp_op_e             op_i,
  output dp_status_t         status_o,
  output logic [OutW-1:0]    out_data_o
);

  localparam int Rows  = (MAX_FRAMES + 3) / 4;
  localparam int RowW  = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int RowBw = 4 * FRAME_ID_BITS;

  // Frame table: one row per map register, four ids to a row.
  logic [RowBw-1:0] map_mem [Rows];
  logic [Rows-1:0]  row_vld_q;
  logic [RowBw-1:0] rd_cur_q;
  logic [RowBw-1:0] rd_last_q;
  logic [RowBw-1:0] wr_row_data;
  logic [CfgIdxW-1:0] wr_row_full;
  logic [RowW-1:0]  wr_row;
  logic             wr_en;
  logic [RowW-1:0]  rd_row_cur;
  logic [RowW-1:0]  rd_row_last;

  logic [KindW-1:0]  kind_q;
  logic [DtW-1:0]    dt_q;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [PosW-1:0]   cur_q, cur_d;
  logic [PosW-1:0]   last_q, last_d;
  logic              run_q, run_d;
  event_e            ev_q, ev_d;
  logic [ProdW-1:0]  prod_q;
  logic [BaseW-1:0]  base_q;
  logic [ProdW-1:0]  x_q;
  logic              gt_q;
  logic [BlendW-1:0] blend_q, blend_d;
  logic [OutW-1:0]   out_q;

  logic [TimerW-1:0] d_eff;
  logic [CountW-1:0] n_eff;
  logic [PosW-1:0]   n_last;
  logic [DivW-1:0]   sum;
  logic              sum_ge;
  logic [PosW-1:0]   pos_q_raw;
  logic [PosW-1:0]   pos_new;
  logic              blend_direct;
  logic [FidW-1:0]   fid_cur;
  logic [FidW-1:0]   fid_last;

  logic              div_start;
  logic [TimerW-1:0] div_rem_init;
  logic [DivW-1:0]   div_num;
  logic [StepW-1:0]  div_steps;
  logic              div_done;
  logic [TimerW-1:0] div_rem;
  logic [DivW-1:0]   div_quo;

  always_comb begin
    d_eff = (cfg_i.duration == '0) ? TimerW'(1) : cfg_i.duration;
    if (cfg_i.frame_count == '0) begin
      n_eff = CountW'(1);
    end else if (cfg_i.frame_count > CountW'(MAX_FRAMES)) begin
      n_eff = CountW'(MAX_FRAMES);
    end else begin
      n_eff = cfg_i.frame_count;
    end
    n_last       = PosW'(n_eff - CountW'(1));
    sum          = {1'b0, timer_q} + DivW'(dt_q);
    sum_ge       = sum >= DivW'(d_eff);
    pos_q_raw    = div_quo[PosW-1:0];
    pos_new      = (pos_q_raw > n_last) ? n_last : pos_q_raw;
    blend_direct = !gt_q || (x_q >= ProdW'(d_eff));
  end

  // Divider operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_rem_init = '0;
    div_num      = '0;
    div_steps    = StepsMod;
    case (op_i)
      DP_MOD_SUM: begin
        div_start = 1'b1;
        div_num   = sum;
      end
      DP_MOD_TIMER: begin
        div_start = 1'b1;
        div_num   = {1'b0, timer_q};
      end
      DP_POS_DIV: begin
        // The product is below count * duration, so its upper part is
        // already below the divisor.
        div_start    = 1'b1;
        div_rem_init = prod_q[TimerW+PosW-1:PosW];
        div_num      = {prod_q[PosW-1:0], (DivW-PosW)'(0)};
        div_steps    = StepsPos;
      end
      DP_BLEND_CHK: begin
        div_start    = !blend_direct;
        div_rem_init = x_q[TimerW-1:0];
        div_steps    = StepsBlend;
      end
      default: begin
      end
    endcase
  end

  tfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .num_i      (div_num),
    .steps_i    (div_steps),
    .divisor_i  (d_eff),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .quo_o      (div_quo)
  );

  // Architectural state updates.
  always_comb begin
    timer_d = timer_q;
    cur_d   = cur_q;
    last_d  = last_q;
    run_d   = run_q;
    ev_d    = ev_q;
    blend_d = blend_q;
    case (op_i)
      DP_CAPTURE: ev_d = EV_NONE;
      DP_TICK_SUM: timer_d = sum[TimerW-1:0];
      DP_TICK_END: begin
        timer_d = d_eff;
        last_d  = cur_q;
        cur_d   = n_last;
        run_d   = 1'b0;
        ev_d    = EV_END;
      end
      DP_LOOP_SET: begin
        timer_d = div_rem;
        ev_d    = EV_LOOP;
      end
      DP_START_SET: begin
        timer_d = div_rem;
        last_d  = '0;
        if (cur_q > n_last) begin
          cur_d = n_last;
        end
        run_d = 1'b1;
        ev_d  = EV_START;
      end
      DP_STOP: begin
        timer_d = '0;
        run_d   = 1'b0;
      end
      DP_POS_FORCE: begin
        last_d = cur_q;
        cur_d  = pos_new;
      end
      DP_POS_CHANGE: begin
        if (pos_new != cur_q) begin
          if (cfg_i.wrap_frames && (pos_new < cur_q)) begin
            ev_d = EV_LOOP;
          end
          last_d = cur_q;
          cur_d  = pos_new;
        end
      end
      DP_BLEND_CHK: begin
        if (blend_direct) begin
          blend_d = gt_q ? BlendOne : '0;
        end
      end
      DP_BLEND_SET: blend_d = BlendW'(div_quo[StepsBlend-1:0]);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      cur_q   <= '0;
      last_q  <= '0;
      run_q   <= 1'b0;
      ev_q    <= EV_NONE;
    end else begin
      timer_q <= timer_d;
      cur_q   <= cur_d;
      last_q  <= last_d;
      run_q   <= run_d;
      ev_q    <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blend_q <= blend_d;
    if (op_i == DP_CAPTURE) begin
      kind_q <= kind_i;
      dt_q   <= dt_i;
    end
    if ((op_i == DP_POS_MUL) || (op_i == DP_BLEND_MUL)) begin
      prod_q <= ProdW'(timer_q) * ProdW'(n_eff);
    end
    if (op_i == DP_BLEND_MUL) begin
      base_q <= BaseW'(cur_q) * BaseW'(d_eff);
    end
    if (op_i == DP_BLEND_SUB) begin
      gt_q <= prod_q > ProdW'(base_q);
      x_q  <= prod_q - ProdW'(base_q);
    end
    if (op_i == DP_OUT_LOAD) begin
      out_q <= {4'b0000, ev_q, run_q, blend_q, fid_last, fid_cur, last_q, cur_q};
    end
  end

  // Frame table write and registered reads.
  always_comb begin
    wr_row_full = map_idx_i - REG_MAP0;
    wr_row      = RowW'(wr_row_full);
    wr_en       = map_we_i && (map_idx_i >= REG_MAP0) && (wr_row_full < CfgIdxW'(Rows));
    for (int k = 0; k < 4; k++) begin
      wr_row_data[k*FRAME_ID_BITS +: FRAME_ID_BITS] = map_data_i[k*FidW +: FRAME_ID_BITS];
    end
    rd_row_cur  = RowW'(cur_q >> 2);
    rd_row_last = RowW'(last_q >> 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en) begin
      row_vld_q[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_row] <= wr_row_data;
    end
    if (op_i == DP_BLEND_MUL) begin
      rd_cur_q  <= row_vld_q[rd_row_cur] ? map_mem[rd_row_cur] : '0;
      rd_last_q <= row_vld_q[rd_row_last] ? map_mem[rd_row_last] : '0;
    end
  end

  always_comb begin
    fid_cur  = FidW'(rd_cur_q[FRAME_ID_BITS*cur_q[1:0] +: FRAME_ID_BITS]);
    fid_last = FidW'(rd_last_q[FRAME_ID_BITS*last_q[1:0] +: FRAME_ID_BITS]);
  end

  always_comb begin
    status_o.kind         = kind_q;
    status_o.running      = run_q;
    status_o.sum_ge       = sum_ge;
    status_o.looping      = cfg_i.looping;
    status_o.div_done     = div_done;
    status_o.blend_direct = blend_direct;
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/tfs_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer controller: walks each request through the datapath steps and
// owns both handshakes.
module tfs_ctrl import tfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  ctrl_state_e state_q, state_d;
  logic        force_q, force_d;
  logic        out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      force_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      force_q   <= force_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    force_d    = force_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    op_o       = DP_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = DP_CAPTURE;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((status_i.kind == KindTick) && status_i.running) begin
          if (status_i.sum_ge) begin
            if (status_i.looping) begin
              op_o    = DP_MOD_SUM;
              force_d = 1'b1;
              state_d = ST_MOD_WAIT;
            end else begin
              op_o    = DP_TICK_END;
              state_d = ST_BLEND_MUL;
            end
          end else begin
            op_o    = DP_TICK_SUM;
            force_d = 1'b0;
            state_d = ST_POS_MUL;
          end
        end else if (status_i.kind == KindStart) begin
          op_o    = DP_MOD_TIMER;
          state_d = ST_START_WAIT;
        end else if (status_i.kind == KindStop) begin
          op_o    = DP_STOP;
          state_d = ST_BLEND_MUL;
        end else begin
          state_d = ST_BLEND_MUL;
        end
      end
      ST_MOD_WAIT: begin
        if (status_i.div_done) begin
          op_o    = DP_LOOP_SET;
          state_d = ST_POS_MUL;
        end
      end
      ST_START_WAIT: begin
        if (status_i.div_done) begin
          op_o    = DP_START_SET;
          state_d = ST_BLEND_MUL;
        end
      end
      ST_POS_MUL: begin
        op_o    = DP_POS_MUL;
        state_d = ST_POS_DIV;
      end
      ST_POS_DIV: begin
        op_o    = DP_POS_DIV;
        state_d = ST_POS_WAIT;
      end
      ST_POS_WAIT: begin
        if (status_i.div_done) begin
          op_o    = force_q ? DP_POS_FORCE : DP_POS_CHANGE;
          state_d = ST_BLEND_MUL;
        end
      end
      ST_BLEND_MUL: begin
        op_o    = DP_BLEND_MUL;
        state_d = ST_BLEND_SUB;
      end
      ST_BLEND_SUB: begin
        op_o    = DP_BLEND_SUB;
        state_d = ST_BLEND_CHK;
      end
      ST_BLEND_CHK: begin
        op_o    = DP_BLEND_CHK;
        state_d = status_i.blend_direct ? ST_OUT : ST_BLEND_WAIT;
      end
      ST_BLEND_WAIT: begin
        if (status_i.div_done) begin
          op_o    = DP_BLEND_SET;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || out_ready_i) begin
          op_o      = DP_OUT_LOAD;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_vld_q;

endmodule

// ===== rtl/timed_frame_sequencer_core.sv =====
`timescale 1ns / 1ps

// Channel       | Direction | Handshake                 | Payload
// --------------+-----------+---------------------------+-----------------------------
// s_axis        | in        | s_axis_tvalid/tready      | tdata: delta_time; tuser: kind
// m_axis        | out       | m_axis_tvalid/tready      | tdata: position .. event_res
// configuration | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One request is handled at a time; the next waits until the last result is loaded.
// The shared one-bit-per-cycle divider finds the timer remainder on a start or a looping
// wrap, the position on a tick and the blend when it is partial.
// Reset clears the timer, both positions and the running flag and loads the register
// defaults; the frame table reads as zero until written.
// A waiting result blocks no request; only a second finished result waits for the first.
module timed_frame_sequencer_core import tfs_pkg::*; #(
  parameter int MAX_FRAMES    = MaxFramesDef,
  parameter int FRAME_ID_BITS = FrameIdBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Requests.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DtW-1:0]     s_axis_tdata,   // [15:0] delta_time
  input  logic [KindW-1:0]   s_axis_tuser,   // [1:0] kind
  // Results.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [3:0] position, [7:4] previous_position, [15:8] frame_id,
  // [23:16] previous_frame_id, [32:24] blend, [33] playing,
  // [35:34] event_res, [39:36] zero
  output logic [OutW-1:0]    m_axis_tdata,
  // Configuration writes.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // The scalar settings live here; the frame table is held in the datapath
  // next to the read ports that use it.
  logic [TimerW-1:0] dur_q;
  logic [CountW-1:0] count_q;
  logic              loop_q;
  logic              wrap_q;
  cfg_t              cfg;
  dp_status_t        status;
  dp_op_e            op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q   <= DurationRst;
      count_q <= CountRst;
      loop_q  <= 1'b0;
      wrap_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DURATION: dur_q   <= cfg_data_i[TimerW-1:0];
        REG_COUNT:    count_q <= cfg_data_i[CountW-1:0];
        REG_LOOPING:  loop_q  <= cfg_data_i[0];
        REG_WRAP:     wrap_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.duration    = dur_q;
    cfg.frame_count = count_q;
    cfg.looping     = loop_q;
    cfg.wrap_frames = wrap_q;
  end

  tfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .op_o        (op)
  );

  tfs_dp #(
    .MAX_FRAMES    (MAX_FRAMES),
    .FRAME_ID_BITS (FRAME_ID_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .map_we_i   (cfg_we_i),
    .map_idx_i  (cfg_idx_i),
    .map_data_i (cfg_data_i),
    .kind_i     (s_axis_tuser),
    .dt_i       (s_axis_tdata),
    .op_i       (op),
    .status_o   (status),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ===== verif/timed_frame_sequencer_core_tb.sv =====
`timescale 1ns / 1ps

module timed_frame_sequencer_core_tb;
  import tfs_pkg::*;

  // The spare request kind is not named by the package, yet the block must ignore it.
  localparam logic [KindW-1:0] KindSpare = KindW'(3);
  localparam int unsigned RandomRequests = 1350;
  // Quiet time after the last result, for the block to settle.
  localparam int unsigned SettleCycles = 100;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DtW-1:0]   delta_time;
  } seq_request_t;

  // Layout of a result on m_axis_tdata, most significant field first.
  typedef struct packed {
    logic [3:0]        pad;
    logic [EventW-1:0] event_res;
    logic              playing;
    logic [BlendW-1:0] blend;
    logic [FidW-1:0]   prev_frame_id;
    logic [FidW-1:0]   frame_id;
    logic [PosW-1:0]   prev_position;
    logic [PosW-1:0]   position;
  } frame_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DtW-1:0]     s_axis_tdata  = '0;   // [15:0] delta_time
  logic [KindW-1:0]   s_axis_tuser  = '0;   // [1:0] kind
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [3:0] position, [7:4] previous_position, [15:8] frame_id,
  // [23:16] previous_frame_id, [32:24] blend, [33] playing,
  // [35:34] event_res, [39:36] zero
  logic [OutW-1:0]    m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [CfgW-1:0]    cfg_data_i    = '0;

  timed_frame_sequencer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Our own copy of the register file, updated as each write is issued.
  logic [TimerW-1:0] cfg_duration = DurationRst;
  logic [CountW-1:0] cfg_count    = CountRst;
  logic              cfg_looping  = 1'b0;
  logic              cfg_wrap     = 1'b0;
  logic [CfgW-1:0]   cfg_map [4]  = '{default: '0};

  // Our own copy of the animation state, advanced on every accepted request.
  logic [TimerW-1:0] seq_timer    = '0;
  logic [PosW-1:0]   seq_pos      = '0;
  logic [PosW-1:0]   seq_prev_pos = '0;
  logic              seq_running  = 1'b0;

  seq_request_t  pending_requests [$];
  frame_result_t expected_frames [$];
  seq_request_t  presented_req;
  frame_result_t seen_frame;
  frame_result_t want_frame;

  int unsigned send_gap     = 0;
  int unsigned send_burst   = 1;
  int unsigned ready_hold   = 0;
  int unsigned issued_count = 0;
  int unsigned result_count = 0;
  int unsigned start_count  = 0;
  int unsigned loop_count   = 0;
  int unsigned end_count    = 0;
  int unsigned settings_count = 1;
  int unsigned mismatch_count = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // A generous ceiling: the slowest legal run needs well under a fifth of this.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned active_duration();
    return (cfg_duration == '0) ? 1 : cfg_duration;
  endfunction

  // Frame count as the block uses it: zero counts as one, anything large as the maximum.
  function automatic longint unsigned active_count();
    if (cfg_count == '0) return 1;
    if (cfg_count > MaxFramesDef) return MaxFramesDef;
    return cfg_count;
  endfunction

  function automatic logic [PosW-1:0] position_for(input longint unsigned t,
                                                   input longint unsigned dur,
                                                   input longint unsigned cnt);
    longint unsigned p;
    p = (t * cnt) / dur;
    if (p > cnt - 1) p = cnt - 1;
    return PosW'(p);
  endfunction

  function automatic logic [FidW-1:0] frame_id_for(input logic [PosW-1:0] p);
    logic [CfgW-1:0] word;
    word = cfg_map[p[3:2]];
    return word[p[1:0] * 8 +: FidW];
  endfunction

  function automatic void move_position(input logic [PosW-1:0] p);
    seq_prev_pos = seq_pos;
    seq_pos      = p;
  endfunction

  // Applies one accepted request to the animation state and queues the result it must give.
  task automatic advance_sequencer(input seq_request_t req);
    longint unsigned dur, cnt, total, num, base, frac;
    logic [PosW-1:0] next_pos;
    frame_result_t   res;
    res = '0;
    res.event_res = EV_NONE;
    dur = active_duration();
    cnt = active_count();
    if (req.kind == KindTick && seq_running) begin
      total = seq_timer + req.delta_time;
      if (total >= dur) begin
        if (cfg_looping) begin
          seq_timer = TimerW'(total % dur);
          move_position(position_for(seq_timer, dur, cnt));
          res.event_res = EV_LOOP;
        end else begin
          // Without looping the sequence parks on its last frame and stops.
          seq_timer = TimerW'(dur);
          move_position(PosW'(cnt - 1));
          seq_running = 1'b0;
          res.event_res = EV_END;
        end
      end else begin
        seq_timer = TimerW'(total);
        next_pos = position_for(seq_timer, dur, cnt);
        if (next_pos != seq_pos) begin
          if (cfg_wrap && next_pos < seq_pos) res.event_res = EV_LOOP;
          move_position(next_pos);
        end
      end
    end else if (req.kind == KindStart) begin
      // A start repairs state left over from an earlier setting.
      seq_timer = TimerW'(seq_timer % dur);
      seq_prev_pos = '0;
      if (seq_pos > cnt - 1) seq_pos = PosW'(cnt - 1);
      seq_running = 1'b1;
      res.event_res = EV_START;
    end else if (req.kind == KindStop) begin
      seq_timer   = '0;
      seq_running = 1'b0;
    end
    num  = seq_timer * cnt;
    base = seq_pos * dur;
    frac = 0;
    if (num > base) begin
      frac = ((num - base) * 256) / dur;
      if (frac > 256) frac = 256;
    end
    res.position      = seq_pos;
    res.prev_position = seq_prev_pos;
    res.frame_id      = frame_id_for(seq_pos);
    res.prev_frame_id = frame_id_for(seq_prev_pos);
    res.blend         = BlendW'(frac);
    res.playing       = seq_running;
    expected_frames = {expected_frames, res};
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) advance_sequencer(presented_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          presented_req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= presented_req.delta_time;
          s_axis_tuser  <= presented_req.kind;
          if (send_burst > 1) begin
            send_burst--;
          end else begin
            // Now and then a long burst with no gaps at all.
            send_burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
            send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result against the oldest prediction and stalls the block
  // with short and long stretches of low tready, broken by long stretches of no stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_frame = m_axis_tdata;
        result_count++;
        case (seen_frame.event_res)
          EV_START: start_count++;
          EV_LOOP:  loop_count++;
          EV_END:   end_count++;
          default: ;
        endcase
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with nothing expected, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want_frame = expected_frames.pop_front();
          check_field("position", want_frame.position, seen_frame.position);
          check_field("previous_position", want_frame.prev_position,
                      seen_frame.prev_position);
          check_field("frame_id", want_frame.frame_id, seen_frame.frame_id);
          check_field("previous_frame_id", want_frame.prev_frame_id,
                      seen_frame.prev_frame_id);
          check_field("blend", want_frame.blend, seen_frame.blend);
          check_field("playing", want_frame.playing, seen_frame.playing);
          check_field("event_res", want_frame.event_res, seen_frame.event_res);
          check_field("padding", want_frame.pad, seen_frame.pad);
        end
      end
      if (ready_hold != 0) begin
        ready_hold--;
      end else if (m_axis_tready) begin
        m_axis_tready <= 1'b0;
        ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 4);
      end else begin
        m_axis_tready <= 1'b1;
        ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400)
                                                 : $urandom_range(0, 20);
      end
    end
  end

  task automatic queue_request(input logic [KindW-1:0] kind, input logic [DtW-1:0] dt);
    seq_request_t req;
    req.kind       = kind;
    req.delta_time = dt;
    pending_requests = {pending_requests, req};
    issued_count++;
  endtask

  // Registers are only written with nothing queued, presented or outstanding.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_frames.size() != 0);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_DURATION: cfg_duration = value[TimerW-1:0];
      REG_COUNT:    cfg_count    = value[CountW-1:0];
      REG_LOOPING:  cfg_looping  = value[0];
      REG_WRAP:     cfg_wrap     = value[0];
      default:      cfg_map[idx[1:0]] = value;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Tick lengths mostly scaled to one frame, so that ends and wraps come often.
  function automatic logic [DtW-1:0] pick_delta();
    int unsigned     sel;
    longint unsigned span;
    sel  = $urandom_range(0, 99);
    span = 2 * (active_duration() / active_count()) + 2;
    if (span > 65535) span = 65535;
    if (sel < 55) return DtW'($urandom_range(0, int'(span)));
    if (sel < 80) return DtW'($urandom_range(0, 65535));
    if (sel < 90) return '0;
    return '1;
  endfunction

  initial begin
    int unsigned sel, len, random_base;
    logic [CfgW-1:0] map_word;

    wait (rst_ni);

    // Reset settings: a tick and the spare kind while stopped, then a start, tick and stop.
    queue_request(KindTick, 16'hFFFF);
    queue_request(KindSpare, 16'hAAAA);
    queue_request(KindStart, 16'h5555);
    queue_request(KindTick, 16'hFFFF);
    queue_request(KindStop, 16'h0000);
    wait_idle();

    settings_count++;
    write_register(REG_DURATION, 32'd1000);
    write_register(REG_COUNT, 32'd16);
    write_register(REG_LOOPING, 32'd0);
    write_register(REG_WRAP, 32'd1);
    write_register(REG_MAP0, 32'h33221100);
    write_register(REG_MAP1, 32'h77665544);
    write_register(REG_MAP2, 32'hBBAA9988);
    write_register(REG_MAP3, 32'hFFEEDDCC);
    // Zero-length tick, the smallest step, a mid step, then an overshoot that ends the run.
    queue_request(KindStart, 16'h0000);
    queue_request(KindTick, 16'h0000);
    queue_request(KindTick, 16'h0001);
    queue_request(KindTick, 16'd300);
    queue_request(KindTick, 16'hFFFF);
    queue_request(KindTick, 16'd5);
    queue_request(KindStart, 16'h0000);
    queue_request(KindTick, 16'd999);
    queue_request(KindStop, 16'h0000);
    wait_idle();

    // Lower the frame count under the stored position: ids are still read at the old
    // position, a start clamps it and the next tick then steps backwards.
    settings_count++;
    write_register(REG_COUNT, 32'd4);
    write_register(REG_LOOPING, 32'd1);
    queue_request(KindTick, 16'd7);
    queue_request(KindStart, 16'h0000);
    queue_request(KindTick, 16'h0000);
    queue_request(KindTick, 16'hFFFF);
    queue_request(KindSpare, 16'h0000);
    wait_idle();

    // Out-of-range settings: zero duration and zero frame count.
    settings_count++;
    write_register(REG_DURATION, 32'd0);
    write_register(REG_COUNT, 32'd0);
    queue_request(KindStart, 16'h0000);
    queue_request(KindTick, 16'hFFFF);
    wait_idle();

    // Longest duration with a frame count above the maximum.
    settings_count++;
    write_register(REG_DURATION, 32'hFFFFFF);
    write_register(REG_COUNT, 32'd31);
    write_register(REG_LOOPING, 32'd0);
    queue_request(KindStart, 16'h0000);
    queue_request(KindTick, 16'hFFFF);

    // Random phases: each retunes the registers, then mostly plays a run with
    // random tick lengths, with restarts, stops and spare kinds mixed in.
    random_base = issued_count;
    while (issued_count - random_base < RandomRequests) begin
      wait_idle();
      settings_count++;
      sel = $urandom_range(0, 99);
      if (sel < 15)      write_register(REG_DURATION, $urandom_range(1, 16));
      else if (sel < 55) write_register(REG_DURATION, $urandom_range(17, 4000));
      else if (sel < 85) write_register(REG_DURATION, $urandom_range(4001, 300000));
      else if (sel < 95) write_register(REG_DURATION, $urandom_range(300001, 24'hFFFFFF));
      else write_register(REG_DURATION, ($urandom_range(0, 1) != 0) ? 32'hFFFFFF : 32'd1);
      sel = $urandom_range(0, 99);
      if (sel < 85)      write_register(REG_COUNT, $urandom_range(1, 16));
      else if (sel < 93) write_register(REG_COUNT, ($urandom_range(0, 1) != 0) ? 32'd16 : 32'd1);
      else               write_register(REG_COUNT, $urandom_range(0, 31));
      if ($urandom_range(0, 1) != 0) write_register(REG_LOOPING, $urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) write_register(REG_WRAP, $urandom_range(0, 1));
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          sel = $urandom_range(0, 9);
          map_word = (sel == 0) ? '0 : (sel == 1) ? '1 : CfgW'($urandom);
          write_register(cfg_reg_e'(REG_MAP0 + i), map_word);
        end
      end
      if ($urandom_range(0, 6) != 0) queue_request(KindStart, DtW'($urandom));
      len = $urandom_range(15, 70);
      repeat (len) begin
        sel = $urandom_range(0, 99);
        if (sel < 10)      queue_request(KindStart, DtW'($urandom));
        else if (sel < 14) queue_request(KindStop, DtW'($urandom));
        else if (sel < 16) queue_request(KindSpare, DtW'($urandom));
        else               queue_request(KindTick, pick_delta());
      end
    end

    wait_idle();
    // Any stray result in this window is flagged by the monitor.
    repeat (SettleCycles) @(posedge clk_i);

    $display("Ran %0d requests under %0d register settings; %0d results were checked.",
             issued_count, settings_count, result_count);
    $display("Results included %0d starts, %0d loop completions and %0d ends.",
             start_count, loop_count, end_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
